@@ rtl/core/sss_pkg.sv @@
`default_nettype none

package sss_pkg;

    typedef enum logic [1:0] {
        FUNC_TICK       = 2'd0,
        FUNC_SEG_WRITE  = 2'd1,
        FUNC_SET_LENGTH = 2'd2,
        FUNC_SCROLL_RST = 2'd3
    } func_t;

    localparam logic [3:0] PHASE_LED   = 4'd4;
    localparam logic [3:0] PHASE_LAST  = 4'd8;
    localparam logic [3:0] PHASE_UPPER = 4'd5;

    localparam logic [15:0] SCROLL_PERIOD_RESET = 16'd500;

    localparam logic [7:0] LOWER_ENABLE [4] = '{8'h10, 8'h20, 8'h40, 8'h80};
    localparam logic [7:0] UPPER_ENABLE [4] = '{8'h01, 8'h02, 8'h04, 8'h08};

    // What a scan tick carries while its segment byte is read from the store.
    typedef struct packed {
        logic       use_store;
        logic [7:0] port_m;
        logic [7:0] port_j;
        logic [7:0] key_column;
    } scan_meta_t;

endpackage

`default_nettype wire

@@ rtl/core/sss_ram.sv @@
`default_nettype none

module sss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/seven_segment_scan_scroll.sv @@
// Scan ticks: the segment store read registers at the accepting edge, and the output
// register loads from it when the output is empty or not stalled, offering the word.
// One word is accepted per clock cycle while in_stall is low; writes, length settings and
// scroll resets take effect at acceptance and produce no result.
// Reset clears the scan phase, offsets, scroll flag, lengths and pipeline valid flags,
// loads the scroll timer with twice the period, marks every segment store entry blank.
`default_nettype none

module seven_segment_scan_scroll
    import sss_pkg::*;
#(
    parameter int MAX_CHARS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  func,
    input  wire logic        display_sel,
    input  wire logic [2:0]  char_index,
    input  wire logic [7:0]  seg_value,
    input  wire logic [3:0]  text_length,
    input  wire logic [3:0]  led_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       segments,
    output logic [7:0]       port_m,
    output logic [7:0]       port_j,
    output logic             key_strobe_valid,
    output logic [7:0]       key_column
);

    localparam int DEPTH     = 2 * MAX_CHARS;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int OFS_W     = $clog2(MAX_CHARS);
    localparam int LEN_W     = $clog2(MAX_CHARS + 1);
    localparam int SUM_W     = $clog2(MAX_CHARS + 3);
    localparam int MOD_STEPS = (MAX_CHARS + 2) / 5;

    // Offset plus digit stays below MAX_CHARS + 3 and a scrolled length is at least five,
    // so (MAX_CHARS + 2) / 5 conditional subtractions give the remainder.
    function automatic logic [SUM_W-1:0] wrap_pos(input logic [SUM_W-1:0] sum,
                                                  input logic [LEN_W-1:0] len);
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] n;
        r = sum;
        n = SUM_W'(len);
        for (int i = 0; i < MOD_STEPS; i++)
        begin
            if (r >= n)
            begin
                r = r - n;
            end
        end
        return r;
    endfunction

    // Architectural state
    logic [15:0]      scroll_period_reg;
    logic [3:0]       scan_phase_reg,   scan_phase_next;
    logic [OFS_W-1:0] lower_offset_reg, lower_offset_next;
    logic [OFS_W-1:0] upper_offset_reg, upper_offset_next;
    logic             scroll_flag_reg,  scroll_flag_next;
    logic [16:0]      scroll_timer_reg, scroll_timer_next;
    logic [7:0]       port_j_hold_reg,  port_j_hold_next;
    logic [LEN_W-1:0] text_len_reg [2];
    logic [LEN_W-1:0] text_len_next [2];
    logic [DEPTH-1:0] seg_written_reg, seg_written_next;

    // Pipeline
    logic       s1_valid_reg, s1_valid_next;
    scan_meta_t s1_meta_reg,  s1_meta_next;
    logic       s1_written_reg;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] segments_reg, port_m_reg, port_j_reg, key_column_reg;

    logic accept;
    logic tick_accept;
    logic s2_load;
    func_t func_code;

    // Scan tick evaluation
    logic [15:0]      period_ticks;
    logic             timer_active;
    logic [16:0]      timer_dec;
    logic             flag_tick;
    logic [3:0]       phase;
    logic             is_lower;
    logic             is_led;
    logic [1:0]       digit;
    logic [LEN_W-1:0] cur_len;
    logic [OFS_W-1:0] cur_off;
    logic             scrolling;
    logic             step;
    logic [LEN_W-1:0] off_inc;
    logic [OFS_W-1:0] off_new;
    logic [OFS_W-1:0] pos;
    logic [7:0]       tick_pm;
    logic [7:0]       tick_pj;
    logic [7:0]       tick_col;

    logic [ADDR_W-1:0] ram_waddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_we;
    logic [7:0]        ram_rdata;

    assign func_code   = func_t'(func);
    assign in_stall    = s1_valid_reg && out_valid_reg && out_stall;
    assign accept      = in_valid && !in_stall;
    assign tick_accept = accept && (func_code == FUNC_TICK);
    assign s2_load     = s1_valid_reg && (!out_valid_reg || !out_stall);

    assign period_ticks = (scroll_period_reg == 16'd0) ? 16'd1 : scroll_period_reg;

    always_comb
    begin
        timer_active = (scroll_timer_reg != 17'd0);
        timer_dec    = timer_active ? (scroll_timer_reg - 17'd1) : scroll_timer_reg;
        flag_tick    = scroll_flag_reg || (timer_active && (timer_dec == 17'd0));

        phase    = (scan_phase_reg > PHASE_LAST) ? 4'd0 : scan_phase_reg;
        is_lower = (phase < PHASE_LED);
        is_led   = (phase == PHASE_LED);
        digit    = is_lower ? phase[1:0] : 2'(phase - PHASE_UPPER);

        cur_len   = is_lower ? text_len_reg[1] : text_len_reg[0];
        cur_off   = is_lower ? lower_offset_reg : upper_offset_reg;
        scrolling = !is_led && (cur_len > LEN_W'(4));
        step      = scrolling && flag_tick;

        off_inc = LEN_W'(cur_off) + LEN_W'(1);
        if (step)
        begin
            off_new = (off_inc >= cur_len) ? '0 : OFS_W'(off_inc);
        end
        else
        begin
            off_new = cur_off;
        end

        if (scrolling)
        begin
            pos = OFS_W'(wrap_pos(SUM_W'(off_new) + SUM_W'(digit), cur_len));
        end
        else
        begin
            pos = OFS_W'(digit);
        end

        tick_pm  = 8'h00;
        tick_pj  = port_j_hold_reg;
        tick_col = 8'h00;
        if (is_lower)
        begin
            if (phase == 4'd0)
            begin
                tick_col = LOWER_ENABLE[0];
            end
            if (phase < 4'd2)
            begin
                tick_pj = 8'h00;
                tick_pm = LOWER_ENABLE[digit];
            end
            else
            begin
                tick_pj = LOWER_ENABLE[digit];
            end
        end
        else if (is_led)
        begin
            tick_pm = {4'h0, led_bits};
        end
        else
        begin
            if (digit != 2'd0)
            begin
                tick_col = UPPER_ENABLE[digit];
            end
            tick_pj = 8'h00;
            tick_pm = UPPER_ENABLE[digit];
        end

        if (is_lower)
        begin
            ram_raddr = ADDR_W'(MAX_CHARS) + ADDR_W'(pos);
        end
        else
        begin
            ram_raddr = ADDR_W'(pos);
        end
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = display_sel ? (ADDR_W'(MAX_CHARS) + ADDR_W'(char_index))
                                : ADDR_W'(char_index);

        scan_phase_next   = scan_phase_reg;
        lower_offset_next = lower_offset_reg;
        upper_offset_next = upper_offset_reg;
        scroll_flag_next  = scroll_flag_reg;
        scroll_timer_next = scroll_timer_reg;
        port_j_hold_next  = port_j_hold_reg;
        text_len_next     = text_len_reg;
        seg_written_next  = seg_written_reg;

        if (accept)
        begin
            unique case (func_code)
                FUNC_TICK:
                begin
                    scroll_timer_next = step ? 17'(period_ticks) : timer_dec;
                    scroll_flag_next  = flag_tick && !step;
                    if (is_lower)
                    begin
                        lower_offset_next = off_new;
                    end
                    else if (!is_led)
                    begin
                        upper_offset_next = off_new;
                    end
                    port_j_hold_next = tick_pj;
                    scan_phase_next  = (phase >= PHASE_LAST) ? 4'd0 : (phase + 4'd1);
                end
                FUNC_SEG_WRITE:
                begin
                    if (32'(char_index) < MAX_CHARS)
                    begin
                        ram_we                      = 1'b1;
                        seg_written_next[ram_waddr] = 1'b1;
                    end
                end
                FUNC_SET_LENGTH:
                begin
                    text_len_next[display_sel] = (32'(text_length) > MAX_CHARS)
                                                 ? LEN_W'(MAX_CHARS)
                                                 : LEN_W'(text_length);
                end
                FUNC_SCROLL_RST:
                begin
                    lower_offset_next = '0;
                    upper_offset_next = '0;
                    scroll_flag_next  = 1'b0;
                    scroll_timer_next = {period_ticks, 1'b0};
                end
                default:
                begin
                    scan_phase_next = scan_phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (tick_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end

        s1_meta_next.use_store  = !is_led;
        s1_meta_next.port_m     = tick_pm;
        s1_meta_next.port_j     = tick_pj;
        s1_meta_next.key_column = tick_col;

        out_valid_next = out_valid_reg;
        if (s2_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scroll_period_reg <= SCROLL_PERIOD_RESET;
            scan_phase_reg    <= '0;
            lower_offset_reg  <= '0;
            upper_offset_reg  <= '0;
            scroll_flag_reg   <= 1'b0;
            scroll_timer_reg  <= {SCROLL_PERIOD_RESET, 1'b0};
            port_j_hold_reg   <= '0;
            text_len_reg      <= '{default: '0};
            seg_written_reg   <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                scroll_period_reg <= cfg_wr_data;
            end
            scan_phase_reg   <= scan_phase_next;
            lower_offset_reg <= lower_offset_next;
            upper_offset_reg <= upper_offset_next;
            scroll_flag_reg  <= scroll_flag_next;
            scroll_timer_reg <= scroll_timer_next;
            port_j_hold_reg  <= port_j_hold_next;
            text_len_reg     <= text_len_next;
            seg_written_reg  <= seg_written_next;
            s1_valid_reg     <= s1_valid_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // The written flag is sampled together with the store read, so both hold while stalled.
    always_ff @(posedge clk)
    begin
        if (tick_accept)
        begin
            s1_meta_reg    <= s1_meta_next;
            s1_written_reg <= seg_written_reg[ram_raddr];
        end
        if (s2_load)
        begin
            segments_reg   <= (s1_meta_reg.use_store && s1_written_reg) ? ram_rdata : 8'h00;
            port_m_reg     <= s1_meta_reg.port_m;
            port_j_reg     <= s1_meta_reg.port_j;
            key_column_reg <= s1_meta_reg.key_column;
        end
    end

    sss_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_seg_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (seg_value),
        .re    (tick_accept),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid        = out_valid_reg;
    assign segments         = segments_reg;
    assign port_m           = port_m_reg;
    assign port_j           = port_j_reg;
    assign key_column       = key_column_reg;
    assign key_strobe_valid = (key_column_reg != 8'h00);

endmodule

`default_nettype wire
